FILE: src/dmmr_pkg.sv
package dmmr_pkg;

   typedef enum logic [3:0] {
      OP_ABS    = 4'd0,
      OP_FLOOR  = 4'd1,
      OP_CEIL   = 4'd2,
      OP_TRUNC  = 4'd3,
      OP_ROUND  = 4'd4,
      OP_FROUND = 4'd5,
      OP_SIGN   = 4'd6,
      OP_MIN    = 4'd7,
      OP_MAX    = 4'd8
   } opcode_type;

   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;

endpackage

FILE: src/dmmr_fround.sv
module dmmr_fround (
   input  logic [63:0] x,
   output logic [63:0] y
);
   import dmmr_pkg::*;

   logic        neg;
   logic [10:0] e;
   logic [52:0] sig;
   logic [6:0]  s;
   logic [52:0] shifted_out;
   logic [52:0] half;
   logic [24:0] k;
   logic [24:0] k_up;
   logic        is_nan;
   logic        rnd_up;
   logic        normal;
   logic [10:0] out_exp;

   // x = sig * 2^(e-1075); single grid step is 2^(max(e,897)-1046)
   always_comb begin
      neg         = x[63];
      e           = x[62:52];
      sig         = {1'b1, x[51:0]};
      is_nan      = (e == 11'h7FF) && (x[51:0] != 52'd0);
      if (e < 11'd897) begin
         s = (11'd926 - e > 11'd60) ? 7'd60 : 7'((11'd926 - e));
      end else begin
         s = 7'd29;
      end
      shifted_out = sig & ((53'd1 << s) - 53'd1);
      half        = 53'd1 << (s - 7'd1);
      k           = 25'(sig >> s);
      rnd_up      = (shifted_out > half) || ((shifted_out == half) && k[0]);
      k_up        = k + {24'd0, rnd_up};
      y           = {neg, 63'd0};
      out_exp     = 11'd0;
      normal      = 1'b0;
      if (e == 11'h7FF) begin
         y = is_nan ? ({x[63:29], 29'd0} | QUIET_BIT) : x;
      end else if (e == 11'd0 || e < 11'd873) begin
         // below half the smallest single subnormal: always a signed zero
         y = {neg, 63'd0};
      end else if (e > 11'd1150) begin
         y = {neg, 63'd0} | EXP_MASK;
      end else if (e < 11'd897) begin
         // single subnormal range; k_up[23] set means it became normal
         if (k_up == 25'd0) begin
            y = {neg, 63'd0};
         end else if (k_up[23]) begin
            y = {neg, 11'd897, k_up[22:0], 29'd0};
         end else begin
            normal = 1'b0;
            y      = {neg, 63'd0};
            for (int i = 22; i >= 0; i--) begin
               if (!normal && k_up[i]) begin
                  normal  = 1'b1;
                  out_exp = 11'(874 + i);
                  y       = {neg, out_exp, 52'd0};
                  y[51:0] = 52'(({27'd0, k_up} << (52 - i))) & 52'hF_FFFF_FFFF_FFFF;
               end
            end
         end
      end else begin
         if (k_up[24]) begin
            out_exp = e + 11'd1;
            y = (out_exp > 11'd1150) ? ({neg, 63'd0} | EXP_MASK)
                                     : {neg, out_exp, 52'd0};
         end else begin
            y = {neg, e, k_up[22:0], 29'd0};
         end
      end
   end

endmodule

FILE: src/double_min_max_round_unit.sv
// A request passes through the input register and then the result register before rsp valid.
// Throughput: one item per cycle while rsp_stall is low; the result path is a single combinational pass.
// A stalled result holds in the output register; the input register keeps moving
// whenever the output register is empty or being drained.
// Reset (synchronous, active high) clears both valid flags; payloads are not reset.
module double_min_max_round_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_bits
);
   import dmmr_pkg::*;

   logic        in_valid_ff;
   logic [3:0]  op_ff;
   logic [63:0] a_ff;
   logic [63:0] b_ff;
   logic        out_valid_ff;
   logic [63:0] out_ff;
   logic [63:0] result_in;
   logic        out_free;
   logic        in_free;
   logic [63:0] fround_y;

   logic        neg;
   logic [10:0] e;
   logic        a_nan;
   logic        b_nan;
   logic        a_zero;
   logic [5:0]  f;
   logic [63:0] fmask;
   logic [63:0] frac;
   logic [63:0] half;
   logic [63:0] trunc_v;
   logic        up;
   logic [63:0] integral;
   logic [63:0] key_a;
   logic [63:0] key_b;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_result_bits = out_ff;

   dmmr_fround u_fround (
      .x(a_ff),
      .y(fround_y)
   );

   always_comb begin
      neg    = a_ff[63];
      e      = a_ff[62:52];
      a_nan  = (e == 11'h7FF) && (a_ff[51:0] != 52'd0);
      b_nan  = (b_ff[62:52] == 11'h7FF) && (b_ff[51:0] != 52'd0);
      a_zero = (a_ff[62:0] == 63'd0);
      f      = (e >= 11'd1023 && e < 11'd1075) ? 6'(11'd1075 - e) : 6'd1;
      fmask  = (64'd1 << f) - 64'd1;
      frac   = a_ff & fmask;
      half   = 64'd1 << (f - 6'd1);
      trunc_v = a_ff & ~fmask;
      up     = 1'b0;
      integral = a_ff;
      if (e == 11'h7FF) begin
         integral = (a_nan && op_ff != OP_ROUND) ? (a_ff | QUIET_BIT) : a_ff;
      end else if (a_zero || e >= 11'd1075) begin
         integral = a_ff;
      end else if (e < 11'd1023) begin
         priority case (op_ff)
            OP_FLOOR: up = neg;
            OP_CEIL:  up = !neg;
            OP_ROUND: up = (e == 11'd1022) && (!neg || a_ff[51:0] != 52'd0);
            default:  up = 1'b0;
         endcase
         integral = up ? ({neg, 63'd0} | ONE_BITS) : {neg, 63'd0};
      end else begin
         priority case (op_ff)
            OP_FLOOR: up = neg && frac != 64'd0;
            OP_CEIL:  up = !neg && frac != 64'd0;
            OP_ROUND: up = neg ? (frac > half) : (frac >= half);
            default:  up = 1'b0;
         endcase
         integral = up ? trunc_v + (64'd1 << f) : trunc_v;
      end

      key_a = a_ff[63] ? ~a_ff : (a_ff | SIGN_BIT);
      key_b = b_ff[63] ? ~b_ff : (b_ff | SIGN_BIT);

      case (op_ff)
         OP_ABS:    result_in = a_ff & ~SIGN_BIT;
         OP_FLOOR, OP_CEIL, OP_TRUNC, OP_ROUND: result_in = integral;
         OP_FROUND: result_in = fround_y;
         OP_SIGN:   result_in = (a_nan || a_zero) ? a_ff : ({neg, 63'd0} | ONE_BITS);
         OP_MIN:    result_in = (a_nan || b_nan) ? CANON_NAN
                                : ((key_a <= key_b) ? a_ff : b_ff);
         OP_MAX:    result_in = (a_nan || b_nan) ? CANON_NAN
                                : ((key_a >= key_b) ? a_ff : b_ff);
         default:   result_in = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_free) in_valid_ff <= req_valid;
         if (out_free) out_valid_ff <= in_valid_ff;
      end
      if (in_free && req_valid) begin
         op_ff <= req_opcode;
         a_ff  <= req_operand_a;
         b_ff  <= req_operand_b;
      end
      if (out_free && in_valid_ff) out_ff <= result_in;
   end

endmodule

FILE: tb/double_min_max_round_unit_tb.sv
module double_min_max_round_unit_tb;
   import dmmr_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int CALM_ITEMS   = 200;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 40;
   localparam logic [63:0] FRAC_BITS = 64'h000F_FFFF_FFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_opcode;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_bits;

   double_min_max_round_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_bits(rsp_result_bits)
   );

   typedef struct {
      logic [3:0]  op;
      logic [63:0] a;
      logic [63:0] b;
      logic        known;
      logic [63:0] res;
   } stim_row_type;

   logic [63:0] pending_results[$];
   int          error_count;
   int          sent_count;
   int          got_count;
   int          cycle_count;
   bit          calm;
   bit          hold_done;
   bit          stim_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_nan(logic [63:0] x);
      return x[62:52] == 11'h7FF && x[51:0] != 0;
   endfunction

   // mode: floor, ceil, trunc or round half up
   function automatic logic [63:0] integral_of(logic [63:0] x, opcode_type mode);
      logic [63:0] neg;
      int          ue;
      int          f;
      logic [63:0] fmask;
      logic [63:0] frac;
      logic [63:0] half;
      logic [63:0] t;
      bit          up;
      neg = x & SIGN_BIT;
      ue = int'(x[62:52]) - 1023;
      if (x[62:52] == 11'h7FF) begin
         if (x[51:0] != 0 && mode != OP_ROUND) return x | QUIET_BIT;
         return x;
      end
      if ((x & ~SIGN_BIT) == 0) return x;
      if (ue >= 52) return x;
      if (ue < 0) begin
         case (mode)
            OP_FLOOR: up = neg != 0;
            OP_CEIL:  up = neg == 0;
            OP_TRUNC: up = 0;
            default:  up = (neg == 0) ? (ue == -1) : (ue == -1 && x[51:0] != 0);
         endcase
         return up ? (neg | ONE_BITS) : neg;
      end
      f = 52 - ue;
      fmask = (64'd1 << f) - 1;
      frac = x & fmask;
      half = 64'd1 << (f - 1);
      t = x & ~fmask;
      case (mode)
         OP_FLOOR: up = neg != 0 && frac != 0;
         OP_CEIL:  up = neg == 0 && frac != 0;
         OP_TRUNC: up = 0;
         default:  up = (neg == 0) ? (frac >= half) : (frac > half);
      endcase
      return up ? t + (64'd1 << f) : t;
   endfunction

   function automatic logic [63:0] single_rounded(logic [63:0] x);
      logic [63:0] neg;
      int          ue;
      int          s;
      int          q;
      int          len;
      logic [63:0] sig;
      logic [63:0] k;
      logic [63:0] rem;
      logic [63:0] half;
      neg = x & SIGN_BIT;
      if (x[62:52] == 11'h7FF) begin
         if (x[51:0] == 0) return x;
         return (x & ~((64'd1 << 29) - 1)) | QUIET_BIT;
      end
      if (x[62:52] == 0) return neg;
      ue = int'(x[62:52]) - 1023;
      if (ue > 127) return neg | EXP_MASK;
      if (ue < -151) return neg;
      sig = (x & FRAC_BITS) | (64'd1 << 52);
      s = 29 + ((ue < -126) ? (-126 - ue) : 0);
      q = ((ue < -126) ? -126 : ue) - 23;
      k = sig >> s;
      rem = sig & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && k[0])) k++;
      if (k == 0) return neg;
      len = 0;
      while (len < 64 && (k >> len) > 1) len++;
      len++;
      if (q + len - 1 > 127) return neg | EXP_MASK;
      return neg | (64'(q + len - 1 + 1023) << 52) | ((k << (53 - len)) & FRAC_BITS);
   endfunction

   function automatic logic [63:0] total_order(logic [63:0] x);
      return x[63] ? ~x : (x | SIGN_BIT);
   endfunction

   function automatic logic [63:0] predict_result(logic [3:0] op, logic [63:0] a,
                                                  logic [63:0] b);
      case (op)
         OP_ABS: return a & ~SIGN_BIT;
         OP_FLOOR, OP_CEIL, OP_TRUNC, OP_ROUND: return integral_of(a, opcode_type'(op));
         OP_FROUND: return single_rounded(a);
         OP_SIGN: begin
            if (is_nan(a) || (a & ~SIGN_BIT) == 0) return a;
            return (a & SIGN_BIT) | ONE_BITS;
         end
         OP_MIN, OP_MAX: begin
            if (is_nan(a) || is_nan(b)) return CANON_NAN;
            if (op == OP_MAX) return (total_order(a) >= total_order(b)) ? a : b;
            return (total_order(a) <= total_order(b)) ? a : b;
         end
         default: return 64'd0;
      endcase
   endfunction

   // double with random sign, an exponent mostly near the integer boundary
   function automatic logic [63:0] random_double();
      logic [10:0] e;
      logic [51:0] m;
      case ($urandom_range(0, 9))
         0: e = 11'h7FF;
         1: e = 11'h000;
         2: e = 11'($urandom);
         3: e = 11'($urandom_range(1023 - 160, 1023 - 120));
         default: e = 11'($urandom_range(1023 - 3, 1023 + 55));
      endcase
      m = 52'({$urandom, $urandom});
      case ($urandom_range(0, 5))
         0: m = m & ~((52'd1 << $urandom_range(0, 51)) - 52'd1);
         1: m = '0;
         2: m[28:0] = 29'h1000_0000;
         default: ;
      endcase
      return {1'($urandom), e, m};
   endfunction

   stim_row_type directed[] = '{
      '{OP_ABS,    64'hFFF8_0000_0000_0001, 64'h0, 1, 64'h7FF8_0000_0000_0001},
      '{OP_ABS,    64'h8000_0000_0000_0000, 64'h0, 1, 64'h0},
      '{OP_FLOOR,  64'hBFE0_0000_0000_0000, 64'h0, 1, 64'hBFF0_0000_0000_0000},
      '{OP_FLOOR,  64'h7FF0_0000_0000_0001, 64'h0, 1, 64'h7FF8_0000_0000_0001},
      '{OP_CEIL,   64'h3FE0_0000_0000_0000, 64'h0, 1, 64'h3FF0_0000_0000_0000},
      '{OP_CEIL,   64'hFFF0_0000_0000_0000, 64'h0, 1, 64'hFFF0_0000_0000_0000},
      '{OP_TRUNC,  64'hBFEF_FFFF_FFFF_FFFF, 64'h0, 1, 64'h8000_0000_0000_0000},
      '{OP_TRUNC,  64'h4330_0000_0000_0001, 64'h0, 1, 64'h4330_0000_0000_0001},
      '{OP_ROUND,  64'h3FDF_FFFF_FFFF_FFFF, 64'h0, 1, 64'h0},
      '{OP_ROUND,  64'hBFE0_0000_0000_0000, 64'h0, 1, 64'h8000_0000_0000_0000},
      '{OP_ROUND,  64'h3FE0_0000_0000_0000, 64'h0, 1, 64'h3FF0_0000_0000_0000},
      '{OP_ROUND,  64'h7FF0_0000_0000_0001, 64'h0, 1, 64'h7FF0_0000_0000_0001},
      '{OP_ROUND,  64'h432F_FFFF_FFFF_FFFF, 64'h0, 0, 64'h0},
      '{OP_FROUND, 64'hFFF0_0000_FFFF_FFFF, 64'h0, 1, 64'hFFF8_0000_E000_0000},
      '{OP_FROUND, 64'h47F0_0000_0000_0000, 64'h0, 1, 64'h7FF0_0000_0000_0000},
      '{OP_FROUND, 64'h8000_0000_0000_0001, 64'h0, 1, 64'h8000_0000_0000_0000},
      '{OP_FROUND, 64'h36A0_0000_0000_0001, 64'h0, 0, 64'h0},
      '{OP_FROUND, 64'h3680_0000_0000_0001, 64'h0, 0, 64'h0},
      '{OP_FROUND, 64'h3FF0_0000_1000_0000, 64'h0, 0, 64'h0},
      '{OP_SIGN,   64'h8000_0000_0000_0000, 64'h0, 1, 64'h8000_0000_0000_0000},
      '{OP_SIGN,   64'hC123_4567_89AB_CDEF, 64'h0, 1, 64'hBFF0_0000_0000_0000},
      '{OP_MIN,    64'h0, 64'h8000_0000_0000_0000, 1, 64'h8000_0000_0000_0000},
      '{OP_MAX,    64'h8000_0000_0000_0000, 64'h0, 1, 64'h0},
      '{OP_MAX,    64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1, CANON_NAN},
      '{OP_MIN,    64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1, 64'hFFF0_0000_0000_0000},
      '{4'hF,      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0}
   };

   // called at a falling edge; valid stays high between back-to-back items
   task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b, bit known,
                            logic [63:0] res);
      logic [63:0] predicted;
      predicted = predict_result(op, a, b);
      if (known && predicted !== res) begin
         $display("%0t: table row op %0d expected %h, predictor gives %h",
                  $time, op, res, predicted);
         error_count++;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(known ? res : predicted);
      sent_count++;
      @(negedge clock);
   endtask

   initial begin
      logic [3:0] op;
      error_count = 0;
      sent_count = 0;
      calm = 0;
      stim_done = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_item(directed[i].op, directed[i].a, directed[i].b, directed[i].known,
                   directed[i].res);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1;
         op = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
         send_item(op, random_double(),
                   ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : random_double(),
                   0, 64'h0);
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // receiver: random stalls, one long hold-off early on so the pipe backs up
   initial begin
      rsp_stall = 1'b0;
      hold_done = 0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count > 40) begin
            hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer, result %h", $time, rsp_result_bits);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_bits !== want) begin
               $display("%0t: result_bits mismatch, expected %h actual %h",
                        $time, want, rsp_result_bits);
               error_count++;
            end
         end
      end
   end

   initial begin
      got_count = 0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     pending_results.size());
            $display("Verification failed");
            $finish;
         end
         if (stim_done && pending_results.size() == 0) begin
            repeat (10) @(posedge clock);
            if (pending_results.size() != 0) error_count++;
            $display("Ran %0d items (directed table plus random across all opcodes),",
                     sent_count);
            $display("%0d results checked, %0d errors", got_count, error_count);
            if (error_count == 0)
               $display("Verification passed");
            else
               $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
